@@ rtl/dhbd_pkg.sv @@
// ----------------------------------------------------------------------------
// DEFLATE Huffman block decoder package
// Shared constants, request codes, status codes and a small helper function.
// ----------------------------------------------------------------------------
package dhbd_pkg;

  // Default sizes.
  localparam int unsigned WINDOW_SIZE_DEF    = 32768;
  localparam int unsigned TABLE_DEPTH_DEF    = 2048;
  localparam int unsigned BYTES_PER_STEP_DEF = 8;

  // Request codes.
  localparam logic [1:0] OP_TABLE_WRITE = 2'd0;
  localparam logic [1:0] OP_PUSH_BYTE   = 2'd1;
  localparam logic [1:0] OP_STEP        = 2'd2;
  localparam logic [1:0] OP_START       = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_NEED = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_EOB  = 3'd3;
  localparam logic [2:0] ST_BAD  = 3'd4;
  localparam logic [2:0] ST_FAR  = 3'd5;

  // Configuration register indexes and reset values.
  localparam logic       CFG_LIT_ROOT  = 1'b0;
  localparam logic       CFG_DIST_ROOT = 1'b1;
  localparam logic [3:0] LIT_ROOT_RST  = 4'd9;
  localparam logic [3:0] DIST_ROOT_RST = 4'd8;

  // Fixed stream constants.
  localparam logic [7:0] REDIRECT_TAG   = 8'h10;
  localparam logic [8:0] MAX_LENGTH     = 9'd258;
  localparam logic [6:0] STEP_MIN_BITS  = 7'd48;
  localparam logic [6:0] PUSH_MAX_BITS  = 7'd56;

  // Mask of the low w bits, for w from 0 to 15.
  function automatic logic [14:0] mask15(input logic [3:0] w);
    logic [15:0] m;
    begin
      m = (16'd1 << w) - 16'd1;
      return m[14:0];
    end
  endfunction

endpackage

@@ rtl/deflate_huffman_block_decoder.sv @@
// ----------------------------------------------------------------------------
// DEFLATE Huffman block decoder
// Decodes literal, end-of-block and length/distance codes through two
// loaded two-level tables and replays back-references from a history RAM.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the in_ channel (valid/stall) and each gives exactly one
// result on the out_ channel. The user must write the two root widths on the
// config port only while the block is idle; the block does not enforce this.
// Table writes, byte pushes, block starts and steps that return at once
// (stopped, need input) go straight from acceptance to the result register.
// A literal passes the root lookup, entry and symbol states, and on a subtable
// hit a subtable lookup and second entry state before the symbol state; a
// length/distance pair then looks up its distance code likewise, ending in
// the distance extra state, through a chain of dependent table RAM reads.
// A copy step reads then writes history per byte, up to BYTES_PER_STEP bytes.
// Only one request is worked on at a time; a new request is taken once the
// block is idle and the result register is free or being emptied.
// When out_stall is high with a result held, it holds and in_stall rises.
// Reset clears the bit buffer, history fill, copy state and stop flag and
// loads the default root widths; tables and history are not cleared.
// ----------------------------------------------------------------------------
module deflate_huffman_block_decoder #(
  parameter int unsigned WINDOW_SIZE    = dhbd_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned TABLE_DEPTH    = dhbd_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned BYTES_PER_STEP = dhbd_pkg::BYTES_PER_STEP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic        in_table_select,
  input  logic [10:0] in_table_index,
  input  logic [31:0] in_table_word,
  input  logic [7:0]  in_source_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_out_bytes,
  output logic [3:0]  out_out_count,
  output logic [2:0]  out_status,
  output logic [6:0]  out_bits_held
);

  localparam int unsigned HAW = $clog2(WINDOW_SIZE);
  localparam int unsigned TAW = $clog2(TABLE_DEPTH);
  localparam int unsigned FW  = $clog2(WINDOW_SIZE + 1);
  localparam logic [HAW:0]   WIN       = (HAW+1)'(WINDOW_SIZE);
  localparam logic [HAW-1:0] WP_LAST   = HAW'(WINDOW_SIZE - 1);
  localparam logic [FW-1:0]  FILL_MAX  = FW'(WINDOW_SIZE);
  localparam logic [16:0]    DEPTH17   = 17'(TABLE_DEPTH);
  localparam logic [3:0]     BPS       = 4'(BYTES_PER_STEP);

  // Sequencer states.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_LK_ROOT = 3'd1;
  localparam logic [2:0] S_LK_ENT  = 3'd2;
  localparam logic [2:0] S_LK_SUB  = 3'd3;
  localparam logic [2:0] S_SYM     = 3'd4;
  localparam logic [2:0] S_DEXT    = 3'd5;
  localparam logic [2:0] S_CP_RD   = 3'd6;
  localparam logic [2:0] S_CP_WR   = 3'd7;

  logic [2:0]     state_r, state_nxt;
  logic [63:0]    buf_r, buf_nxt;
  logic [6:0]     cnt_r, cnt_nxt;
  logic [63:0]    wb_r, wb_nxt;
  logic [6:0]     wc_r, wc_nxt;
  logic [31:0]    e_r, e_nxt;
  logic           lvl_r, lvl_nxt;
  logic           dist_r, dist_nxt;
  logic [8:0]     len_r, len_nxt;
  logic [HAW-1:0] wp_r, wp_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;
  logic [8:0]     crem_r, crem_nxt;
  logic [HAW-1:0] cdm1_r, cdm1_nxt;
  logic           stop_r, stop_nxt;
  logic [3:0]     lroot_r, lroot_nxt;
  logic [3:0]     droot_r, droot_nxt;
  logic [63:0]    acc_r, acc_nxt;
  logic [3:0]     oc_r, oc_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [63:0]    out_bytes_r, out_bytes_nxt;
  logic [3:0]     out_count_r, out_count_nxt;
  logic [2:0]     out_status_r, out_status_nxt;
  logic [6:0]     out_held_r, out_held_nxt;

  // Memory ports.
  logic           lit_we, dist_we;
  logic [TAW-1:0] tab_waddr, tab_raddr;
  logic [31:0]    lit_rdata, dist_rdata;
  logic           hist_we;
  logic [HAW-1:0] hist_raddr;
  logic [7:0]     hist_wdata, hist_rdata;

  // Datapath temporaries.
  logic           accept;
  logic [14:0]    root_idx;
  logic [31:0]    ent;
  logic           ent_term;
  logic [16:0]    sub_idx;
  logic [14:0]    extra;
  logic [16:0]    sum17;
  logic [17:0]    dist18;
  logic [HAW:0]   src_ext;
  logic [63:0]    acc_new;
  logic [HAW-1:0] wp_inc;
  logic [FW-1:0]  fill_inc;

  dhbd_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_lit_ram (
    .clk(clk), .we(lit_we), .waddr(tab_waddr), .wdata(in_table_word),
    .raddr(tab_raddr), .rdata(lit_rdata)
  );

  dhbd_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_dist_ram (
    .clk(clk), .we(dist_we), .waddr(tab_waddr), .wdata(in_table_word),
    .raddr(tab_raddr), .rdata(dist_rdata)
  );

  dhbd_ram #(.WIDTH(8), .DEPTH(WINDOW_SIZE)) u_hist_ram (
    .clk(clk), .we(hist_we), .waddr(wp_r), .wdata(hist_wdata),
    .raddr(hist_raddr), .rdata(hist_rdata)
  );

  // Handshake: one request at a time, result register must be free or being emptied.
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_out_bytes = out_bytes_r;
  assign out_out_count = out_count_r;
  assign out_status    = out_status_r;
  assign out_bits_held = out_held_r;

  // Index and history address arithmetic.
  assign root_idx  = wb_r[14:0] & dhbd_pkg::mask15(dist_r ? droot_r : lroot_r);
  assign sub_idx   = {1'b0, e_r[23:8]} + 17'(wb_r[14:0] & dhbd_pkg::mask15(e_r[7:4]));
  assign tab_raddr = (state_r == S_LK_SUB) ? TAW'(sub_idx) : TAW'(root_idx);
  assign tab_waddr = TAW'(in_table_index);
  assign ent       = dist_r ? dist_rdata : lit_rdata;
  assign ent_term  = dist_r ? (ent[31:30] != 2'b00) : (ent[31:29] != 3'b000);
  assign extra     = wb_r[14:0] & dhbd_pkg::mask15(e_r[7:4]);
  assign sum17     = {1'b0, e_r[23:8]} + 17'(extra);
  assign dist18    = {1'b0, sum17} + 18'd1;
  assign src_ext   = (wp_r > cdm1_r) ?
                     ({1'b0, wp_r} - {1'b0, cdm1_r} - (HAW+1)'(1)) :
                     ({1'b0, wp_r} + WIN - {1'b0, cdm1_r} - (HAW+1)'(1));
  assign hist_raddr = HAW'(src_ext);
  assign wp_inc    = (wp_r == WP_LAST) ? '0 : wp_r + HAW'(1);
  assign fill_inc  = (fill_r < FILL_MAX) ? fill_r + FW'(1) : fill_r;

  always_comb begin
    acc_new = acc_r;
    acc_new[oc_r[2:0]*8 +: 8] = hist_rdata;
  end

  // Sequencer and next-state logic.
  always_comb begin
    state_nxt = state_r;
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    wb_nxt = wb_r;
    wc_nxt = wc_r;
    e_nxt = e_r;
    lvl_nxt = lvl_r;
    dist_nxt = dist_r;
    len_nxt = len_r;
    wp_nxt = wp_r;
    fill_nxt = fill_r;
    crem_nxt = crem_r;
    cdm1_nxt = cdm1_r;
    stop_nxt = stop_r;
    lroot_nxt = lroot_r;
    droot_nxt = droot_r;
    acc_nxt = acc_r;
    oc_nxt = oc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_bytes_nxt = out_bytes_r;
    out_count_nxt = out_count_r;
    out_status_nxt = out_status_r;
    out_held_nxt = out_held_r;
    lit_we = 1'b0;
    dist_we = 1'b0;
    hist_we = 1'b0;
    hist_wdata = hist_rdata;

    // Configuration writes.
    if (cfg_we) begin
      if (cfg_index == dhbd_pkg::CFG_LIT_ROOT) begin
        lroot_nxt = cfg_wdata;
      end else begin
        droot_nxt = cfg_wdata;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_bytes_nxt = '0;
          out_count_nxt = '0;
          out_status_nxt = dhbd_pkg::ST_OK;
          out_held_nxt = cnt_r;
          unique case (in_op)
            dhbd_pkg::OP_TABLE_WRITE: begin
              if ({6'd0, in_table_index} < DEPTH17) begin
                lit_we = !in_table_select;
                dist_we = in_table_select;
              end
            end
            dhbd_pkg::OP_PUSH_BYTE: begin
              if (cnt_r <= dhbd_pkg::PUSH_MAX_BITS) begin
                buf_nxt = buf_r | (64'(in_source_byte) << cnt_r);
                cnt_nxt = cnt_r + 7'd8;
                out_held_nxt = cnt_r + 7'd8;
              end else begin
                out_status_nxt = dhbd_pkg::ST_FULL;
              end
            end
            dhbd_pkg::OP_START: begin
              stop_nxt = 1'b0;
              crem_nxt = '0;
            end
            default: begin
              if (stop_r) begin
                out_status_nxt = dhbd_pkg::ST_EOB;
              end else if (crem_r != '0) begin
                out_valid_nxt = out_valid_r && out_stall;
                acc_nxt = '0;
                oc_nxt = '0;
                state_nxt = S_CP_RD;
              end else if (cnt_r < dhbd_pkg::STEP_MIN_BITS) begin
                out_status_nxt = dhbd_pkg::ST_NEED;
              end else begin
                out_valid_nxt = out_valid_r && out_stall;
                wb_nxt = buf_r;
                wc_nxt = cnt_r;
                dist_nxt = 1'b0;
                state_nxt = S_LK_ROOT;
              end
            end
          endcase
        end
      end

      // Root lookup: the read address is driven from root_idx.
      S_LK_ROOT: begin
        lvl_nxt = 1'b0;
        if ({2'b00, root_idx} >= DEPTH17) begin
          state_nxt = S_IDLE;
          stop_nxt = 1'b1;
          out_valid_nxt = 1'b1;
          out_bytes_nxt = '0;
          out_count_nxt = '0;
          out_status_nxt = dhbd_pkg::ST_BAD;
          out_held_nxt = cnt_r;
        end else begin
          state_nxt = S_LK_ENT;
        end
      end

      // Entry arrives: consume its code bits and classify it.
      S_LK_ENT: begin
        e_nxt = ent;
        if (wc_r < 7'(ent[3:0]) ||
            (!ent_term && (lvl_r || ent[31:24] != dhbd_pkg::REDIRECT_TAG))) begin
          state_nxt = S_IDLE;
          stop_nxt = 1'b1;
          out_valid_nxt = 1'b1;
          out_bytes_nxt = '0;
          out_count_nxt = '0;
          out_status_nxt = dhbd_pkg::ST_BAD;
          out_held_nxt = cnt_r;
        end else begin
          wb_nxt = wb_r >> ent[3:0];
          wc_nxt = wc_r - 7'(ent[3:0]);
          if (ent_term) begin
            state_nxt = dist_r ? S_DEXT : S_SYM;
          end else begin
            state_nxt = S_LK_SUB;
          end
        end
      end

      // Subtable lookup: the read address is driven from sub_idx.
      S_LK_SUB: begin
        lvl_nxt = 1'b1;
        if (sub_idx >= DEPTH17) begin
          state_nxt = S_IDLE;
          stop_nxt = 1'b1;
          out_valid_nxt = 1'b1;
          out_bytes_nxt = '0;
          out_count_nxt = '0;
          out_status_nxt = dhbd_pkg::ST_BAD;
          out_held_nxt = cnt_r;
        end else begin
          state_nxt = S_LK_ENT;
        end
      end

      // Literal, end of block or length.
      S_SYM: begin
        if (e_r[31]) begin
          state_nxt = S_IDLE;
          hist_we = 1'b1;
          hist_wdata = e_r[15:8];
          wp_nxt = wp_inc;
          fill_nxt = fill_inc;
          buf_nxt = wb_r;
          cnt_nxt = wc_r;
          out_valid_nxt = 1'b1;
          out_bytes_nxt = {56'd0, e_r[15:8]};
          out_count_nxt = 4'd1;
          out_status_nxt = dhbd_pkg::ST_OK;
          out_held_nxt = wc_r;
        end else if (!e_r[30]) begin
          state_nxt = S_IDLE;
          buf_nxt = wb_r;
          cnt_nxt = wc_r;
          stop_nxt = 1'b1;
          out_valid_nxt = 1'b1;
          out_bytes_nxt = '0;
          out_count_nxt = '0;
          out_status_nxt = dhbd_pkg::ST_EOB;
          out_held_nxt = wc_r;
        end else if (wc_r < 7'(e_r[7:4])) begin
          state_nxt = S_IDLE;
          stop_nxt = 1'b1;
          out_valid_nxt = 1'b1;
          out_bytes_nxt = '0;
          out_count_nxt = '0;
          out_status_nxt = dhbd_pkg::ST_BAD;
          out_held_nxt = cnt_r;
        end else begin
          len_nxt = (sum17 > 17'(dhbd_pkg::MAX_LENGTH)) ? dhbd_pkg::MAX_LENGTH : sum17[8:0];
          wb_nxt = wb_r >> e_r[7:4];
          wc_nxt = wc_r - 7'(e_r[7:4]);
          dist_nxt = 1'b1;
          state_nxt = S_LK_ROOT;
        end
      end

      // Distance extra bits, range check and copy arming.
      S_DEXT: begin
        state_nxt = S_IDLE;
        out_valid_nxt = 1'b1;
        out_bytes_nxt = '0;
        out_count_nxt = '0;
        out_held_nxt = cnt_r;
        if (wc_r < 7'(e_r[7:4])) begin
          stop_nxt = 1'b1;
          out_status_nxt = dhbd_pkg::ST_BAD;
        end else if (dist18 > 18'(fill_r)) begin
          stop_nxt = 1'b1;
          out_status_nxt = dhbd_pkg::ST_FAR;
        end else begin
          buf_nxt = wb_r >> e_r[7:4];
          cnt_nxt = wc_r - 7'(e_r[7:4]);
          crem_nxt = len_r;
          cdm1_nxt = HAW'(sum17);
          out_status_nxt = dhbd_pkg::ST_OK;
          out_held_nxt = wc_r - 7'(e_r[7:4]);
        end
      end

      // Copy: the history read address is driven from src_ext.
      S_CP_RD: begin
        state_nxt = S_CP_WR;
      end

      // Copy: append the byte read to history and to the result.
      S_CP_WR: begin
        hist_we = 1'b1;
        hist_wdata = hist_rdata;
        wp_nxt = wp_inc;
        fill_nxt = fill_inc;
        acc_nxt = acc_new;
        oc_nxt = oc_r + 4'd1;
        crem_nxt = crem_r - 9'd1;
        if (crem_r == 9'd1 || (oc_r + 4'd1) == BPS) begin
          state_nxt = S_IDLE;
          out_valid_nxt = 1'b1;
          out_bytes_nxt = acc_new;
          out_count_nxt = oc_r + 4'd1;
          out_status_nxt = dhbd_pkg::ST_OK;
          out_held_nxt = cnt_r;
        end else begin
          state_nxt = S_CP_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      buf_r <= '0;
      cnt_r <= '0;
      wp_r <= '0;
      fill_r <= '0;
      crem_r <= '0;
      cdm1_r <= '0;
      stop_r <= 1'b0;
      lroot_r <= dhbd_pkg::LIT_ROOT_RST;
      droot_r <= dhbd_pkg::DIST_ROOT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      buf_r <= buf_nxt;
      cnt_r <= cnt_nxt;
      wp_r <= wp_nxt;
      fill_r <= fill_nxt;
      crem_r <= crem_nxt;
      cdm1_r <= cdm1_nxt;
      stop_r <= stop_nxt;
      lroot_r <= lroot_nxt;
      droot_r <= droot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    wb_r <= wb_nxt;
    wc_r <= wc_nxt;
    e_r <= e_nxt;
    lvl_r <= lvl_nxt;
    dist_r <= dist_nxt;
    len_r <= len_nxt;
    acc_r <= acc_nxt;
    oc_r <= oc_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_count_r <= out_count_nxt;
    out_status_r <= out_status_nxt;
    out_held_r <= out_held_nxt;
  end

  // A result never carries more bytes than one step may emit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r <= BPS))
    else $error("result byte count above step limit");

  // A pending copy and the stop flag never coexist.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(stop_r && crem_r != '0))
    else $error("copy pending while stopped");

  // Every copy byte is written in the cycle after its history read.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CP_RD) |=> (state_r == S_CP_WR && hist_we))
    else $error("copy read not followed by history write");

  // The history fill never passes the window size.
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("history fill above window size");

endmodule

@@ rtl/dhbd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dhbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
